FILE: rtl/i2c_master_line_sequencer_assert.svh
// assertion macros for the i2c master line sequencer checker
// no dependencies; included by the checker file
`ifndef I2C_MASTER_LINE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_LINE_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge
`define I2CMS_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising edge
`define I2CMS_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2cms_pkg.sv
// shared types, codes and helper functions for the i2c master line sequencer
// no dependencies; imported by the step decoder, core, result register and top level
package i2cms_pkg;

    // item kind codes; the idle command shares the tick code
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_SACK  = 3'd5,
        KIND_RACK  = 3'd6,
        KIND_NOP   = 3'd7
    } t_kind;

    localparam t_kind CMD_IDLE = KIND_TICK;

    // what one line step does
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SCL,
        OP_SDA,
        OP_SAMPLE_BIT,
        OP_SAMPLE_ACK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       level;
        logic [2:0] bit_sel;
    } t_step;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       ack_value;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       dropped;
    } t_result;

    localparam logic [15:0] STEP_TICKS_RESET = 16'd10;

    // number of line steps in each command
    function automatic logic [4:0] seq_len(input t_kind cmd);
        logic [4:0] len;
        case (cmd)
            KIND_START: len = 5'd4;
            KIND_STOP:  len = 5'd3;
            KIND_WRITE: len = 5'd24;
            KIND_READ:  len = 5'd25;
            KIND_SACK:  len = 5'd3;
            KIND_RACK:  len = 5'd4;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/i2cms_step_decode.sv
// line step decoder: maps command and step number to one line action
// depends on i2cms_pkg
module i2cms_step_decode (
    input  i2cms_pkg::t_kind i_cmd,
    input  logic [4:0]       i_idx,
    input  logic [7:0]       i_tx,
    output i2cms_pkg::t_step o_step
);
    import i2cms_pkg::*;

    logic [4:0] rel_idx;
    logic [8:0] prod;
    logic [3:0] bit_num;
    logic [4:0] phase_full;
    logic [1:0] phase;
    logic [2:0] msb_sel;

    // bit number and phase within a three-step bit slot; read is offset by one
    always_comb begin
        rel_idx    = (i_cmd == KIND_READ) ? (i_idx - 5'd1) : i_idx;
        // divide by three as multiply by 11/32, exact for 0..31
        prod       = {4'd0, rel_idx} * 9'd11;
        bit_num    = prod[8:5];
        phase_full = rel_idx - ({1'b0, bit_num} + {bit_num, 1'b0});
        phase      = phase_full[1:0];
        msb_sel    = 3'd7 - bit_num[2:0];
    end

    // step table per command
    always_comb begin
        o_step = '{op: OP_NONE, level: 1'b0, bit_sel: msb_sel};
        case (i_cmd)
            KIND_START: begin
                case (i_idx)
                    5'd0:    o_step.op = OP_SDA;
                    5'd1:    o_step.op = OP_SCL;
                    5'd2:    o_step.op = OP_SDA;
                    default: o_step.op = OP_SCL;
                endcase
                o_step.level = (i_idx == 5'd0) || (i_idx == 5'd1);
            end
            KIND_STOP: begin
                o_step.op    = (i_idx == 5'd1) ? OP_SCL : OP_SDA;
                o_step.level = (i_idx != 5'd0);
            end
            KIND_WRITE: begin
                case (phase)
                    2'd0: begin
                        o_step.op    = OP_SDA;
                        o_step.level = i_tx[msb_sel];
                    end
                    2'd1: begin
                        o_step.op    = OP_SCL;
                        o_step.level = 1'b1;
                    end
                    default: begin
                        o_step.op    = OP_SCL;
                        o_step.level = 1'b0;
                    end
                endcase
            end
            KIND_READ: begin
                if (i_idx == 5'd0) begin
                    o_step.op    = OP_SDA;
                    o_step.level = 1'b1;
                end else begin
                    case (phase)
                        2'd0: begin
                            o_step.op    = OP_SCL;
                            o_step.level = 1'b1;
                        end
                        2'd1:    o_step.op = OP_SAMPLE_BIT;
                        default: begin
                            o_step.op    = OP_SCL;
                            o_step.level = 1'b0;
                        end
                    endcase
                end
            end
            KIND_SACK: begin
                o_step.op    = (i_idx == 5'd0) ? OP_SDA : OP_SCL;
                o_step.level = (i_idx == 5'd0) ? i_tx[0] : (i_idx == 5'd1);
            end
            KIND_RACK: begin
                case (i_idx)
                    5'd0: begin
                        o_step.op    = OP_SDA;
                        o_step.level = 1'b1;
                    end
                    5'd1: begin
                        o_step.op    = OP_SCL;
                        o_step.level = 1'b1;
                    end
                    5'd2:    o_step.op = OP_SAMPLE_ACK;
                    default: begin
                        o_step.op    = OP_SCL;
                        o_step.level = 1'b0;
                    end
                endcase
            end
            default: o_step.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/i2cms_core.sv
// sequencer state and per-transaction update of lines, counters and bytes
// depends on i2cms_pkg and i2cms_step_decode
module i2cms_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  i2cms_pkg::t_item   i_item,
    input  logic [15:0]        i_step_ticks,
    output i2cms_pkg::t_result o_result
);
    import i2cms_pkg::*;

    t_kind       r_cmd, n_cmd;
    logic [4:0]  r_idx, n_idx;
    logic [15:0] r_hold, n_hold;
    logic [7:0]  r_shift, n_shift;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_ack, n_ack;
    logic [7:0]  r_tx, n_tx;

    logic        play;
    t_kind       play_cmd;
    logic [4:0]  play_idx;
    logic [7:0]  shift_base;
    logic        done;
    logic        dropped;
    logic [15:0] hold_load;
    logic [4:0]  idx_inc;
    t_step       step;

    // control: which step, if any, this transaction plays
    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_hold     = r_hold;
        n_tx       = r_tx;
        shift_base = r_shift;
        play       = 1'b0;
        play_cmd   = r_cmd;
        play_idx   = r_idx;
        done       = 1'b0;
        dropped    = 1'b0;
        hold_load  = (i_step_ticks == 16'd0) ? 16'd1 : i_step_ticks;
        idx_inc    = r_idx + 5'd1;
        if (i_item.kind == KIND_TICK) begin
            if (r_cmd != CMD_IDLE) begin
                if (r_hold > 16'd1) begin
                    n_hold = r_hold - 16'd1;
                end else if (idx_inc >= seq_len(r_cmd)) begin
                    n_cmd  = CMD_IDLE;
                    n_idx  = 5'd0;
                    n_hold = 16'd0;
                    done   = 1'b1;
                end else begin
                    play     = 1'b1;
                    play_idx = idx_inc;
                    n_idx    = idx_inc;
                    n_hold   = hold_load;
                end
            end
        end else if (i_item.kind != KIND_NOP) begin
            if (r_cmd != CMD_IDLE) begin
                dropped = 1'b1;
            end else begin
                n_cmd    = i_item.kind;
                n_idx    = 5'd0;
                n_hold   = hold_load;
                play     = 1'b1;
                play_cmd = i_item.kind;
                play_idx = 5'd0;
                if (i_item.kind == KIND_WRITE) begin
                    n_tx = i_item.data_byte;
                end else if (i_item.kind == KIND_SACK) begin
                    n_tx = {7'd0, i_item.ack_value};
                end else if (i_item.kind == KIND_READ) begin
                    shift_base = 8'd0;
                end
            end
        end
    end

    i2cms_step_decode u_decode (
        .i_cmd  (play_cmd),
        .i_idx  (play_idx),
        .i_tx   (n_tx),
        .o_step (step)
    );

    // apply the decoded line step
    always_comb begin
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_shift = shift_base;
        if (play) begin
            case (step.op)
                OP_SCL:        n_scl = step.level;
                OP_SDA:        n_sda = step.level;
                OP_SAMPLE_BIT: n_shift[step.bit_sel] = shift_base[step.bit_sel]
                                                       | i_item.sda_level;
                OP_SAMPLE_ACK: n_ack = i_item.sda_level;
                default:       n_ack = r_ack;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_IDLE;
            r_idx   <= 5'd0;
            r_hold  <= 16'd0;
            r_shift <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_tx    <= 8'd0;
        end else if (i_fire) begin
            r_cmd   <= n_cmd;
            r_idx   <= n_idx;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_tx    <= n_tx;
        end
    end

    // result of this transaction, from the updated state
    assign o_result = '{
        scl_level: n_scl,
        sda_drive: n_sda,
        busy_res:  (n_cmd != CMD_IDLE),
        done_res:  done,
        read_byte: n_shift,
        ack_seen:  n_ack,
        dropped:   dropped
    };

endmodule

FILE: rtl/i2cms_out_reg.sv
// result register with valid and stall towards the receiver
// depends on i2cms_pkg
module i2cms_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cms_pkg::t_result i_result,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output i2cms_pkg::t_result o_result
);
    import i2cms_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/i2c_master_line_sequencer.sv
// I2C master line sequencer, top level: input register, sequencer core, result register
// depends on i2cms_pkg, i2cms_core, i2cms_out_reg
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per transaction:
//   a tick (i_kind zero) or a command with its byte, ack bit and the sampled
//   SDA level. Output channel (o_out_valid / i_out_stall) returns exactly one
//   result per item: SCL level, SDA drive, busy, done, read byte, ack, dropped.
//   i_cfg_we with i_cfg_data writes step_ticks; write only while idle.
//   An accepted item waits in the input register until the result register is free.
//   Throughput is one item per cycle while the receiver does not stall: the input
//   register feeds the core, and the core updates its state and loads the result
//   register in the same cycle.
//   When the receiver stalls, the result register holds; one more item is taken
//   into the input register, then o_in_stall rises until the result leaves.
//   Synchronous active-low reset empties both registers, releases SCL and SDA,
//   returns the sequencer to idle and sets step_ticks to 10.
module i2c_master_line_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_ack_value,
    input  logic        i_sda_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic        o_ack_seen,
    output logic        o_dropped,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import i2cms_pkg::*;

    logic        r_in_valid;
    t_item       r_in_item;
    logic [15:0] r_step_ticks;
    logic        out_ready;
    logic        fire;
    logic        in_accept;
    t_result     core_result;
    t_result     out_result;

    // handshake between input register and result register
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= '{kind: t_kind'(i_kind), data_byte: i_data_byte,
                           ack_value: i_ack_value, sda_level: i_sda_level};
        end
    end

    // step_ticks configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks <= STEP_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_step_ticks <= i_cfg_data;
        end
    end

    i2cms_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_step_ticks (r_step_ticks),
        .o_result     (core_result)
    );

    i2cms_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_scl_level = out_result.scl_level;
    assign o_sda_drive = out_result.sda_drive;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_byte = out_result.read_byte;
    assign o_ack_seen  = out_result.ack_seen;
    assign o_dropped   = out_result.dropped;

endmodule

FILE: rtl/i2cms_checker.sv
// port-level checker for the i2c master line sequencer, with its bind
// depends on i2c_master_line_sequencer_assert.svh and the top level
`include "i2c_master_line_sequencer_assert.svh"

module i2cms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_busy_res,
    input logic o_done_res,
    input logic o_dropped
);

    // a stalled result stays offered
    `I2CMS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result withdrawn while stalled")

    // completion leaves the sequencer idle
    `I2CMS_ASSERT_NOW(a_done_idle, i_clk, !i_rst_n, o_out_valid && o_done_res, !o_busy_res, "done while still busy")

    // a command is only dropped while a sequence runs
    `I2CMS_ASSERT_NOW(a_drop_busy, i_clk, !i_rst_n, o_out_valid && o_dropped, o_busy_res, "dropped while idle")

    // a tick cannot both finish and be dropped
    `I2CMS_ASSERT_NOW(a_done_drop, i_clk, !i_rst_n, o_out_valid, !(o_done_res && o_dropped), "done and dropped together")

    // reset empties the result register
    `I2CMS_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind i2c_master_line_sequencer i2cms_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_dropped   (o_dropped)
);

FILE: test/i2c_master_line_sequencer_tb.sv
// testbench for the i2c master line sequencer: queued driver, checking monitor, line predictor
// depends on i2cms_pkg and i2c_master_line_sequencer; self-checking, no external files
`timescale 1ns / 1ps

module i2c_master_line_sequencer_tb;
    import i2cms_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_kind      = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_ack_value = 1'b0;
    logic        i_sda_level = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_scl_level;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        o_ack_seen;
    logic        o_dropped;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = '0;

    // stimulus and expectation stores
    t_item   pending_items[$];
    t_result awaited_levels[$];
    t_item   offered_item;

    // predictor copy of the sequencer state and the step_ticks register
    logic [15:0] step_cfg;
    t_kind       seq_cmd;
    logic [4:0]  seq_pos;
    logic [15:0] seq_hold;
    logic [7:0]  seq_shift;
    logic [7:0]  tx_bits;
    logic        line_scl;
    logic        line_sda;
    logic        ack_bit;

    // stimulus bookkeeping: ticks still needed before the sequencer is idle
    int gen_busy_ticks;
    int items_queued;

    int send_gap_pct;
    int recv_stall_pct;
    int fail_count;
    int results_seen;
    int freeze_left;
    bit freeze_done;
    int cycle_count;

    i2c_master_line_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_ack_value (i_ack_value),
        .i_sda_level (i_sda_level),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scl_level (o_scl_level),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_read_byte (o_read_byte),
        .o_ack_seen  (o_ack_seen),
        .o_dropped   (o_dropped),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // line steps in each command
    function automatic int steps_in_command(input t_kind cmd);
        case (cmd)
            KIND_START: return 4;
            KIND_STOP:  return 3;
            KIND_WRITE: return 24;
            KIND_READ:  return 25;
            KIND_SACK:  return 3;
            KIND_RACK:  return 4;
            default:    return 0;
        endcase
    endfunction

    // a zero setting still holds for one tick
    function automatic logic [15:0] hold_reload();
        return (step_cfg == 16'd0) ? 16'd1 : step_cfg;
    endfunction

    // one line step of a command: drive scl, drive or release sda, or sample sda
    function automatic void apply_line_step(input t_kind cmd, input logic [4:0] idx,
                                            input logic sda_in);
        int pos;
        int bit_no;
        int phase;
        pos = int'(idx);
        case (cmd)
            KIND_START: begin
                case (pos)
                    0:       line_sda = 1'b1;
                    1:       line_scl = 1'b1;
                    2:       line_sda = 1'b0;
                    default: line_scl = 1'b0;
                endcase
            end
            KIND_STOP: begin
                case (pos)
                    0:       line_sda = 1'b0;
                    1:       line_scl = 1'b1;
                    default: line_sda = 1'b1;
                endcase
            end
            KIND_WRITE: begin
                // msb first, three steps per bit
                bit_no = pos / 3;
                phase  = pos % 3;
                if (phase == 0) line_sda = tx_bits[7 - bit_no];
                else line_scl = (phase == 1);
            end
            KIND_READ: begin
                if (pos == 0) begin
                    line_sda = 1'b1;
                end else begin
                    bit_no = (pos - 1) / 3;
                    phase  = (pos - 1) % 3;
                    if (phase == 0) line_scl = 1'b1;
                    else if (phase == 1) begin
                        if (sda_in) seq_shift[7 - bit_no] = 1'b1;
                    end else line_scl = 1'b0;
                end
            end
            KIND_SACK: begin
                case (pos)
                    0:       line_sda = tx_bits[0];
                    1:       line_scl = 1'b1;
                    default: line_scl = 1'b0;
                endcase
            end
            KIND_RACK: begin
                case (pos)
                    0:       line_sda = 1'b1;
                    1:       line_scl = 1'b1;
                    2:       ack_bit  = sda_in;
                    default: line_scl = 1'b0;
                endcase
            end
            default: ;
        endcase
    endfunction

    // advance the predicted sequencer by one transaction and return the line levels
    function automatic t_result line_levels_after(input t_item it);
        t_result r;
        r = '0;
        if (it.kind == KIND_TICK) begin
            if (seq_cmd != CMD_IDLE) begin
                if (seq_hold > 16'd1) begin
                    seq_hold = seq_hold - 16'd1;
                end else begin
                    seq_pos = seq_pos + 5'd1;
                    if (int'(seq_pos) >= steps_in_command(seq_cmd)) begin
                        seq_cmd    = CMD_IDLE;
                        seq_pos    = '0;
                        seq_hold   = '0;
                        r.done_res = 1'b1;
                    end else begin
                        apply_line_step(seq_cmd, seq_pos, it.sda_level);
                        seq_hold = hold_reload();
                    end
                end
            end
        end else if (it.kind != KIND_NOP) begin
            if (seq_cmd != CMD_IDLE) begin
                r.dropped = 1'b1;
            end else begin
                seq_cmd = it.kind;
                seq_pos = '0;
                case (it.kind)
                    KIND_WRITE: tx_bits   = it.data_byte;
                    KIND_SACK:  tx_bits   = {7'd0, it.ack_value};
                    KIND_READ:  seq_shift = '0;
                    default: ;
                endcase
                apply_line_step(seq_cmd, 5'd0, it.sda_level);
                seq_hold = hold_reload();
            end
        end
        r.scl_level = line_scl;
        r.sda_drive = line_sda;
        r.busy_res  = (seq_cmd != CMD_IDLE);
        r.read_byte = seq_shift;
        r.ack_seen  = ack_bit;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // queue one transaction and track how long the sequencer stays busy
    function automatic void queue_item(input t_kind kind, input logic [7:0] data,
                                       input logic ack, input logic sda);
        t_item it;
        it.kind      = kind;
        it.data_byte = data;
        it.ack_value = ack;
        it.sda_level = sda;
        pending_items.push_back(it);
        items_queued++;
        if (kind == KIND_TICK) begin
            if (gen_busy_ticks > 0) gen_busy_ticks--;
        end else if (kind != KIND_NOP && gen_busy_ticks == 0) begin
            gen_busy_ticks = steps_in_command(kind) * int'(hold_reload());
        end
    endfunction

    // ticks until the current command has finished; sda fixed (0, 1) or random (2)
    function automatic void finish_command(input int sda_sel, input bit noise);
        while (gen_busy_ticks > 0) begin
            if (noise && $urandom_range(49) == 0)
                queue_item(t_kind'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                           1'($urandom));
            else
                queue_item(KIND_TICK, 8'($urandom), 1'($urandom),
                           (sda_sel == 2) ? logic'($urandom_range(1)) : logic'(sda_sel));
        end
    endfunction

    function automatic void play_command(input t_kind kind, input logic [7:0] data,
                                         input logic ack, input int sda_sel, input bit noise);
        queue_item(kind, data, ack, 1'($urandom));
        finish_command(sda_sel, noise);
    endfunction

    // mostly well-formed bus transfers with random content, some stray items
    function automatic void random_phase(input int goal);
        int first;
        first = items_queued;
        while (items_queued - first < goal) begin
            if ($urandom_range(9) < 8) begin
                play_command(KIND_START, 8'($urandom), 1'($urandom), 2, 1'b1);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(1)) begin
                        play_command(KIND_WRITE, 8'($urandom), 1'($urandom), 2, 1'b1);
                        play_command(KIND_RACK, 8'($urandom), 1'($urandom), 2, 1'b1);
                    end else begin
                        play_command(KIND_READ, 8'($urandom), 1'($urandom), 2, 1'b1);
                        play_command(KIND_SACK, 8'($urandom), 1'($urandom), 2, 1'b1);
                    end
                end
                play_command(KIND_STOP, 8'($urandom), 1'($urandom), 2, 1'b1);
            end else begin
                case ($urandom_range(2))
                    0: repeat ($urandom_range(1, 6)) queue_item(KIND_TICK, 8'($urandom),
                                                                1'($urandom), 1'($urandom));
                    1: queue_item(KIND_NOP, 8'($urandom), 1'($urandom), 1'($urandom));
                    default: play_command(t_kind'($urandom_range(1, 6)), 8'($urandom),
                                          1'($urandom), 2, 1'b1);
                endcase
            end
        end
    endfunction

    // wait until every queued transaction has produced its result
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || awaited_levels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_step_ticks(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        step_cfg = value;
        @(negedge i_clk);
    endtask

    // driver: offers queued items, predicts each accepted transaction
    always @(posedge i_clk) begin : feed_items
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                awaited_levels.push_back(line_levels_after(offered_item));
                offering = 1'b0;
            end
            if (!offering && pending_items.size() != 0 &&
                $urandom_range(99) >= send_gap_pct) begin
                offered_item = pending_items.pop_front();
                i_kind      <= offered_item.kind;
                i_data_byte <= offered_item.data_byte;
                i_ack_value <= offered_item.ack_value;
                i_sda_level <= offered_item.sda_level;
                offering = 1'b1;
            end
            i_in_valid <= offering;
        end
    end

    // monitor: checks each result transaction, drives the output stall
    always @(posedge i_clk) begin : watch_results
        t_result want;
        logic    hold_back;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_levels.size() == 0) begin
                    $display("%0t: result with nothing expected, got scl %b sda %b busy %b",
                             $time, o_scl_level, o_sda_drive, o_busy_res);
                    fail_count++;
                end else begin
                    want = awaited_levels.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(o_scl_level));
                    check_field("sda_drive", 8'(want.sda_drive), 8'(o_sda_drive));
                    check_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                    check_field("read_byte", want.read_byte, o_read_byte);
                    check_field("ack_seen", 8'(want.ack_seen), 8'(o_ack_seen));
                    check_field("dropped", 8'(want.dropped), 8'(o_dropped));
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (!freeze_done && results_seen >= 200) begin
                freeze_left = 150;
                freeze_done = 1'b1;
            end
            if (freeze_left > 0) begin
                freeze_left--;
                hold_back = 1'b1;
            end else begin
                hold_back = ($urandom_range(99) < recv_stall_pct);
            end
            i_out_stall <= hold_back;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        step_cfg       = STEP_TICKS_RESET;
        seq_cmd        = CMD_IDLE;
        seq_pos        = '0;
        seq_hold       = '0;
        seq_shift      = '0;
        tx_bits        = '0;
        line_scl       = 1'b1;
        line_sda       = 1'b1;
        ack_bit        = 1'b0;
        gen_busy_ticks = 0;
        items_queued   = 0;
        fail_count     = 0;
        results_seen   = 0;
        freeze_left    = 0;
        freeze_done    = 1'b0;
        cycle_count    = 0;
        send_gap_pct   = 15;
        recv_stall_pct = 49;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset hold length, idle tick, no-op kind, command while busy
        queue_item(KIND_TICK, 8'h00, 1'b0, 1'b0);
        queue_item(KIND_NOP, 8'hFF, 1'b1, 1'b1);
        queue_item(KIND_START, 8'h00, 1'b0, 1'b0);
        queue_item(KIND_WRITE, 8'hA5, 1'b1, 1'b1);
        finish_command(2, 0);
        wait_drained();
        set_step_ticks(16'd1);

        // every command but start with extreme data and sampled levels
        play_command(KIND_WRITE, 8'h00, 1'b0, 2, 0);
        play_command(KIND_WRITE, 8'hFF, 1'b1, 2, 0);
        play_command(KIND_RACK, 8'h00, 1'b0, 0, 0);
        play_command(KIND_RACK, 8'h00, 1'b0, 1, 0);
        play_command(KIND_READ, 8'h00, 1'b0, 1, 0);
        play_command(KIND_READ, 8'h00, 1'b0, 0, 0);
        play_command(KIND_READ, 8'h00, 1'b0, 2, 0);
        play_command(KIND_SACK, 8'h00, 1'b0, 2, 0);
        play_command(KIND_SACK, 8'h00, 1'b1, 2, 0);
        queue_item(KIND_STOP, 8'h00, 1'b0, 1'b0);
        queue_item(KIND_NOP, 8'h00, 1'b0, 1'b0);
        queue_item(KIND_STOP, 8'h00, 1'b0, 1'b0);
        finish_command(2, 0);

        random_phase(120);
        finish_command(2, 0);
        wait_drained();

        // zero setting, receiver now the quieter side
        set_step_ticks(16'd0);
        send_gap_pct   = 49;
        recv_stall_pct = 15;
        random_phase(120);
        finish_command(2, 0);
        wait_drained();

        set_step_ticks(16'd3);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_phase(120);
        finish_command(2, 0);
        wait_drained();

        // longest hold: the count runs down from the top, stray items while busy
        set_step_ticks(16'hFFFF);
        queue_item(KIND_SACK, 8'h00, 1'b0, 1'b1);
        queue_item(KIND_READ, 8'hFF, 1'b1, 1'b1);
        queue_item(KIND_NOP, 8'h00, 1'b0, 1'b0);
        repeat (40) queue_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
        wait_drained();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
